FILE: rtl/exb_pkg.sv
`timescale 1ns / 1ps
// Shared types, widths and constants for the Euler XYZ basis rotation.
// No dependencies.
package exb_pkg;

    localparam int COMP_W = 16;
    localparam int ANG_W  = 16;
    localparam int STEPS  = 16;
    localparam int Q_W    = 35;
    localparam int CW     = 34;
    localparam int ZW     = 33;
    localparam int VW     = 20;
    localparam int PW     = VW + CW;
    localparam int SC_LAT = STEPS + 3;

    localparam logic signed [Q_W-1:0] PI_Q30      = 35'sd3373259426;
    localparam logic signed [Q_W-1:0] TWO_PI_Q30  = 35'sd6746518852;
    localparam logic signed [Q_W-1:0] HALF_PI_Q30 = 35'sd1686629713;
    localparam logic signed [CW-1:0]  GAIN_Q30    = 34'sd652032874;

    typedef struct packed {
        logic signed [COMP_W-1:0] u_x, u_y, u_z;
        logic signed [COMP_W-1:0] v_x, v_y, v_z;
        logic signed [COMP_W-1:0] w_x, w_y, w_z;
        logic signed [ANG_W-1:0]  angle_x, angle_y, angle_z;
    } t_in_item;

    typedef struct packed {
        logic signed [COMP_W-1:0] ru_x, ru_y, ru_z;
        logic signed [COMP_W-1:0] rv_x, rv_y, rv_z;
        logic signed [COMP_W-1:0] rw_x, rw_y, rw_z;
    } t_out_item;

    typedef struct packed {
        logic signed [VW-1:0] x, y, z;
    } t_vec;

    typedef t_vec [2:0] t_basis;

    typedef struct packed {
        logic signed [CW-1:0] c, s;
    } t_trig;

    function automatic logic signed [ZW-1:0] atan_q30(input int i);
        logic [31:0] v;
        case (i)
            0:  v = 32'h3243F6A8;
            1:  v = 32'h1DAC6705;
            2:  v = 32'h0FADBAFC;
            3:  v = 32'h07F56EA6;
            4:  v = 32'h03FEAB76;
            5:  v = 32'h01FFD55B;
            6:  v = 32'h00FFFAAA;
            7:  v = 32'h007FFF55;
            8:  v = 32'h003FFFEA;
            9:  v = 32'h001FFFFD;
            10: v = 32'h000FFFFF;
            11: v = 32'h0007FFFF;
            12: v = 32'h0003FFFF;
            13: v = 32'h0001FFFF;
            14: v = 32'h0000FFFF;
            15: v = 32'h00007FFF;
            16: v = 32'h00003FFF;
            17: v = 32'h00001FFF;
            18: v = 32'h00000FFF;
            19: v = 32'h000007FF;
            20: v = 32'h000003FF;
            21: v = 32'h000001FF;
            22: v = 32'h000000FF;
            23: v = 32'h0000007F;
            24: v = 32'h0000003F;
            25: v = 32'h0000001F;
            26: v = 32'h0000000F;
            27: v = 32'h00000008;
            28: v = 32'h00000004;
            29: v = 32'h00000002;
            30: v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return signed'({1'b0, v});
    endfunction

    function automatic logic signed [COMP_W-1:0] sat_comp(input logic signed [VW-1:0] v);
        logic signed [VW-1:0] hi;
        logic signed [VW-1:0] lo;
        hi = VW'((1 << (COMP_W - 1)) - 1);
        lo = -hi - VW'(1);
        if (v > hi) begin
            return COMP_W'(hi);
        end else if (v < lo) begin
            return COMP_W'(lo);
        end
        return COMP_W'(v);
    endfunction

endpackage

FILE: rtl/exb_in_if.sv
`timescale 1ns / 1ps
// Input item channel: valid/ready handshake with the input item payload.
// Depends on exb_pkg.
interface exb_in_if;
    import exb_pkg::*;
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

FILE: rtl/exb_out_if.sv
`timescale 1ns / 1ps
// Result item channel: valid/ready handshake with the rotated basis.
// Depends on exb_pkg.
interface exb_out_if;
    import exb_pkg::*;
    logic      valid;
    logic      ready;
    t_out_item data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

FILE: rtl/exb_sincos.sv
`timescale 1ns / 1ps
// Pipelined sine/cosine: angle reduction, quadrant fold, one CORDIC step per stage.
// Depends on exb_pkg.
module exb_sincos (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  logic signed [exb_pkg::ANG_W-1:0] i_angle,
    output exb_pkg::t_trig               o_trig
);
    import exb_pkg::*;

    logic signed [Q_W-1:0] w_t0;
    logic signed [Q_W-1:0] r_t;
    logic signed [Q_W-1:0] n_t;
    logic signed [Q_W-1:0] w_f;
    logic                  w_fneg;
    logic signed [CW-1:0]  r_x [0:STEPS];
    logic signed [CW-1:0]  r_y [0:STEPS];
    logic signed [ZW-1:0]  r_z [0:STEPS];
    logic                  r_neg [0:STEPS];
    t_trig                 r_trig;

    assign w_t0 = Q_W'(i_angle) <<< 18;

    always_comb begin
        if (w_t0 > PI_Q30) begin
            n_t = w_t0 - TWO_PI_Q30;
        end else if (w_t0 <= -PI_Q30) begin
            n_t = w_t0 + TWO_PI_Q30;
        end else begin
            n_t = w_t0;
        end
    end

    always_comb begin
        w_fneg = 1'b0;
        w_f    = r_t;
        if (r_t > HALF_PI_Q30) begin
            w_f    = r_t - PI_Q30;
            w_fneg = 1'b1;
        end else if (r_t < -HALF_PI_Q30) begin
            w_f    = r_t + PI_Q30;
            w_fneg = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_t      <= n_t;
            r_x[0]   <= GAIN_Q30;
            r_y[0]   <= '0;
            r_z[0]   <= ZW'(w_f);
            r_neg[0] <= w_fneg;
        end
    end

    for (genvar i = 0; i < STEPS; i++) begin : g_step
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_neg[i+1] <= r_neg[i];
                if (r_z[i] >= 0) begin
                    r_x[i+1] <= r_x[i] - (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] + (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] - atan_q30(i);
                end else begin
                    r_x[i+1] <= r_x[i] + (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] - (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] + atan_q30(i);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_trig.c <= r_neg[STEPS] ? -r_x[STEPS] : r_x[STEPS];
            r_trig.s <= r_neg[STEPS] ? -r_y[STEPS] : r_y[STEPS];
        end
    end

    assign o_trig = r_trig;

endmodule

FILE: rtl/exb_rot.sv
`timescale 1ns / 1ps
// One planar rotation of three component pairs: product stage, then round and shift.
// Depends on exb_pkg.
module exb_rot (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic signed [exb_pkg::VW-1:0] i_a [3],
    input  logic signed [exb_pkg::VW-1:0] i_b [3],
    input  exb_pkg::t_trig                i_trig,
    output logic signed [exb_pkg::VW-1:0] o_ra [3],
    output logic signed [exb_pkg::VW-1:0] o_rb [3]
);
    import exb_pkg::*;

    localparam logic signed [PW:0] HALF = (PW+1)'(1) <<< 29;

    logic signed [PW-1:0] r_ac [3];
    logic signed [PW-1:0] r_bs [3];
    logic signed [PW-1:0] r_as [3];
    logic signed [PW-1:0] r_bc [3];
    logic signed [VW-1:0] r_ra [3];
    logic signed [VW-1:0] r_rb [3];

    for (genvar k = 0; k < 3; k++) begin : g_lane
        logic signed [PW:0] w_sa;
        logic signed [PW:0] w_sb;

        assign w_sa = (PW+1)'(r_ac[k]) - (PW+1)'(r_bs[k]) + HALF;
        assign w_sb = (PW+1)'(r_as[k]) + (PW+1)'(r_bc[k]) + HALF;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_ac[k] <= PW'(i_a[k]) * PW'(i_trig.c);
                r_bs[k] <= PW'(i_b[k]) * PW'(i_trig.s);
                r_as[k] <= PW'(i_a[k]) * PW'(i_trig.s);
                r_bc[k] <= PW'(i_b[k]) * PW'(i_trig.c);
                r_ra[k] <= VW'(w_sa >>> 30);
                r_rb[k] <= VW'(w_sb >>> 30);
            end
        end

        assign o_ra[k] = r_ra[k];
        assign o_rb[k] = r_rb[k];
    end

endmodule

FILE: rtl/euler_xyz_basis_rotation.sv
`timescale 1ns / 1ps
// Euler XYZ rotation of a three-vector basis; top level.
// Depends on exb_pkg, exb_in_if, exb_out_if, exb_sincos, exb_rot.
//
// Takes one item per clock while the pipeline is not stalled; each result passes
// through an input register, the 16-step CORDIC pipeline (19 stages with
// reduction, fold and sign fix), three rotation units of two stages each and a
// saturating output register. The whole pipeline advances together whenever
// the output register is empty or being taken, so a stall on the result side
// holds every stage and input ready falls with it.
module euler_xyz_basis_rotation (
    input  logic         i_clk,
    input  logic         i_rst_n,
    exb_in_if.sink       i_item,
    exb_out_if.source    o_item
);
    import exb_pkg::*;

    localparam int LAST = SC_LAT + 7;

    logic      w_en;
    logic      r_vld [0:LAST];
    t_in_item  r_in;
    t_basis    r_d [1:SC_LAT];
    t_trig     w_tx, w_ty, w_tz;
    t_trig     r_ty [0:1];
    t_trig     r_tz [0:3];
    t_basis    r_bx [0:1];
    t_basis    r_by [0:1];
    t_basis    r_bz [0:1];
    t_basis    w_ax, w_ay, w_az;
    t_basis    w_in_b;
    t_out_item r_out;

    logic signed [VW-1:0] w_xa [3], w_xb [3], w_xra [3], w_xrb [3];
    logic signed [VW-1:0] w_ya [3], w_yb [3], w_yra [3], w_yrb [3];
    logic signed [VW-1:0] w_za [3], w_zb [3], w_zra [3], w_zrb [3];

    assign w_en         = !r_vld[LAST] || o_item.ready;
    assign i_item.ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= LAST; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (w_en) begin
            r_vld[0] <= i_item.valid;
            for (int k = 1; k <= LAST; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    always_comb begin
        w_in_b[0] = '{x: VW'(r_in.u_x), y: VW'(r_in.u_y), z: VW'(r_in.u_z)};
        w_in_b[1] = '{x: VW'(r_in.v_x), y: VW'(r_in.v_y), z: VW'(r_in.v_z)};
        w_in_b[2] = '{x: VW'(r_in.w_x), y: VW'(r_in.w_y), z: VW'(r_in.w_z)};
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_in   <= i_item.data;
            r_d[1] <= w_in_b;
            for (int k = 2; k <= SC_LAT; k++) begin
                r_d[k] <= r_d[k-1];
            end
        end
    end

    exb_sincos u_scx (.i_clk(i_clk), .i_en(w_en), .i_angle(r_in.angle_x), .o_trig(w_tx));
    exb_sincos u_scy (.i_clk(i_clk), .i_en(w_en), .i_angle(r_in.angle_y), .o_trig(w_ty));
    exb_sincos u_scz (.i_clk(i_clk), .i_en(w_en), .i_angle(r_in.angle_z), .o_trig(w_tz));

    // about X: (y, z); about Y: (z, x); about Z: (x, y)
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_xa[k] = r_d[SC_LAT][k].y;
            w_xb[k] = r_d[SC_LAT][k].z;
            w_ax[k] = r_bx[1][k];
            w_ax[k].y = w_xra[k];
            w_ax[k].z = w_xrb[k];
            w_ya[k] = w_ax[k].z;
            w_yb[k] = w_ax[k].x;
            w_ay[k] = r_by[1][k];
            w_ay[k].z = w_yra[k];
            w_ay[k].x = w_yrb[k];
            w_za[k] = w_ay[k].x;
            w_zb[k] = w_ay[k].y;
            w_az[k] = r_bz[1][k];
            w_az[k].x = w_zra[k];
            w_az[k].y = w_zrb[k];
        end
    end

    exb_rot u_rotx (.i_clk(i_clk), .i_en(w_en), .i_a(w_xa), .i_b(w_xb), .i_trig(w_tx),
                    .o_ra(w_xra), .o_rb(w_xrb));
    exb_rot u_roty (.i_clk(i_clk), .i_en(w_en), .i_a(w_ya), .i_b(w_yb), .i_trig(r_ty[1]),
                    .o_ra(w_yra), .o_rb(w_yrb));
    exb_rot u_rotz (.i_clk(i_clk), .i_en(w_en), .i_a(w_za), .i_b(w_zb), .i_trig(r_tz[3]),
                    .o_ra(w_zra), .o_rb(w_zrb));

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_ty[0] <= w_ty;
            r_ty[1] <= r_ty[0];
            r_tz[0] <= w_tz;
            for (int k = 1; k < 4; k++) begin
                r_tz[k] <= r_tz[k-1];
            end
            r_bx[0] <= r_d[SC_LAT];
            r_bx[1] <= r_bx[0];
            r_by[0] <= w_ax;
            r_by[1] <= r_by[0];
            r_bz[0] <= w_ay;
            r_bz[1] <= r_bz[0];
            r_out.ru_x <= sat_comp(w_az[0].x);
            r_out.ru_y <= sat_comp(w_az[0].y);
            r_out.ru_z <= sat_comp(w_az[0].z);
            r_out.rv_x <= sat_comp(w_az[1].x);
            r_out.rv_y <= sat_comp(w_az[1].y);
            r_out.rv_z <= sat_comp(w_az[1].z);
            r_out.rw_x <= sat_comp(w_az[2].x);
            r_out.rw_y <= sat_comp(w_az[2].y);
            r_out.rw_z <= sat_comp(w_az[2].z);
        end
    end

    assign o_item.valid = r_vld[LAST];
    assign o_item.data  = r_out;

    a_rst_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !r_vld[0] && !r_vld[LAST])
        else $error("valid bits not cleared by reset");

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_item.valid && i_item.ready |=> r_vld[0])
        else $error("accepted item not captured");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> r_vld[LAST] && $stable(r_out) && $stable(r_vld[0]))
        else $error("pipeline moved while stalled");

endmodule

FILE: tb/euler_xyz_basis_rotation_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for euler_xyz_basis_rotation: a bit-exact CORDIC and
// rotation predictor checks every result item under random idling and stalls.
// Depends on exb_pkg, exb_in_if, exb_out_if and the block's RTL.
module euler_xyz_basis_rotation_tb;
    import exb_pkg::*;

    localparam longint PI_Q     = 64'sd3373259426;
    localparam longint TWO_PI_Q = 64'sd6746518852;
    localparam longint HALF_PI_Q = 64'sd1686629713;
    localparam longint GAIN_Q   = 64'sd652032874;
    localparam int     LATENCY  = 27;
    localparam int     N_RANDOM = 750;

    logic i_clk;
    logic i_rst_n;

    exb_in_if  in_ch ();
    exb_out_if out_ch ();

    euler_xyz_basis_rotation u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (in_ch.sink),
        .o_item  (out_ch.source)
    );

    t_in_item  pending_items[$];
    t_out_item rotated_expected[$];
    int        n_mismatch;
    int        n_sent;
    bit        stim_done;
    bit        drain_hold;
    int        burst_left;
    int        gap_left;
    int        stall_phase;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic longint atan_entry(input int i);
        return longint'(atan_q30(i));
    endfunction

    function automatic void sin_cos(input logic signed [ANG_W-1:0] ang,
                                    output longint c, output longint s);
        longint t;
        longint x;
        longint y;
        longint dx;
        longint dy;
        bit     flip;
        t = longint'(ang) * 262144;
        x = GAIN_Q;
        y = 0;
        flip = 1'b0;
        if (t > PI_Q) t -= TWO_PI_Q;
        else if (t <= -PI_Q) t += TWO_PI_Q;
        if (t > HALF_PI_Q) begin
            t -= PI_Q;
            flip = 1'b1;
        end else if (t < -HALF_PI_Q) begin
            t += PI_Q;
            flip = 1'b1;
        end
        for (int i = 0; i < STEPS && i < 32; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (t >= 0) begin
                x -= dx;
                y += dy;
                t -= atan_entry(i);
            end else begin
                x += dx;
                y -= dy;
                t += atan_entry(i);
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    function automatic void turn(input longint a, input longint b, input longint c,
                                 input longint s, output longint ra, output longint rb);
        ra = (a * c - b * s + (64'sd1 << 29)) >>> 30;
        rb = (a * s + b * c + (64'sd1 << 29)) >>> 30;
    endfunction

    function automatic logic signed [COMP_W-1:0] clamp(input longint v);
        if (v > 32767) return 16'sh7fff;
        if (v < -32768) return 16'sh8000;
        return v[COMP_W-1:0];
    endfunction

    function automatic t_out_item rotate_basis(input t_in_item it);
        longint cx, sx, cy, sy, cz, sz;
        longint vx, vy, vz, p, q;
        logic signed [COMP_W-1:0] src[9];
        logic signed [COMP_W-1:0] dst[9];
        t_out_item r;
        sin_cos(it.angle_x, cx, sx);
        sin_cos(it.angle_y, cy, sy);
        sin_cos(it.angle_z, cz, sz);
        src = '{it.u_x, it.u_y, it.u_z, it.v_x, it.v_y, it.v_z, it.w_x, it.w_y, it.w_z};
        for (int k = 0; k < 3; k++) begin
            vx = longint'(src[3*k]);
            vy = longint'(src[3*k+1]);
            vz = longint'(src[3*k+2]);
            turn(vy, vz, cx, sx, p, q);
            vy = p;
            vz = q;
            turn(vz, vx, cy, sy, p, q);
            vz = p;
            vx = q;
            turn(vx, vy, cz, sz, p, q);
            vx = p;
            vy = q;
            dst[3*k]   = clamp(vx);
            dst[3*k+1] = clamp(vy);
            dst[3*k+2] = clamp(vz);
        end
        r = '{dst[0], dst[1], dst[2], dst[3], dst[4], dst[5], dst[6], dst[7], dst[8]};
        return r;
    endfunction

    function automatic logic signed [15:0] pick_comp();
        case ($urandom_range(0, 5))
            0: return 16'sh7fff;
            1: return 16'sh8000;
            2: return 16'sh4000;
            3: return 16'shc000;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic t_in_item random_item();
        t_in_item it;
        it.u_x = pick_comp(); it.u_y = pick_comp(); it.u_z = pick_comp();
        it.v_x = pick_comp(); it.v_y = pick_comp(); it.v_z = pick_comp();
        it.w_x = pick_comp(); it.w_y = pick_comp(); it.w_z = pick_comp();
        it.angle_x = 16'($urandom);
        it.angle_y = ($urandom_range(0, 3) == 0) ? 16'sd0 : 16'($urandom);
        it.angle_z = 16'($urandom);
        return it;
    endfunction

    function automatic t_in_item basis_item(input logic signed [15:0] a,
                                            input logic signed [15:0] b,
                                            input logic signed [15:0] c);
        t_in_item it;
        it = '{16'sh4000, 16'sd0, 16'sd0, 16'sd0, 16'sh4000, 16'sd0,
               16'sd0, 16'sd0, 16'sh4000, a, b, c};
        return it;
    endfunction

    initial begin
        t_in_item it;
        // identity, quarter turns, half-turn boundaries, whole turns and the angle extremes
        pending_items.push_back(basis_item(16'sd0, 16'sd0, 16'sd0));
        pending_items.push_back(basis_item(16'sd6434, 16'sd0, 16'sd0));
        pending_items.push_back(basis_item(16'sd0, 16'sd6434, 16'sd0));
        pending_items.push_back(basis_item(16'sd0, 16'sd0, 16'sd6434));
        pending_items.push_back(basis_item(16'sd12868, 16'sd12868, 16'sd12868));
        pending_items.push_back(basis_item(-16'sd12868, -16'sd12868, -16'sd12868));
        pending_items.push_back(basis_item(16'sd12867, -16'sd12867, 16'sd12869));
        pending_items.push_back(basis_item(16'sh7fff, 16'sh8000, 16'sh7fff));
        pending_items.push_back(basis_item(16'sh8000, 16'sh7fff, 16'sh8000));
        pending_items.push_back(basis_item(16'sd25736, -16'sd25736, 16'sd19302));
        pending_items.push_back(basis_item(-16'sd6434, -16'sd6435, 16'sd6435));
        // saturation: full-scale components at diagonal angles
        it = '{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh8000,
               16'sh7fff, 16'sh8000, 16'sh7fff, 16'sd3217, 16'sd3217, 16'sd3217};
        pending_items.push_back(it);
        it = '{16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff,
               16'sh8000, 16'sh8000, 16'sh8000, -16'sd3217, 16'sd3217, -16'sd3217};
        pending_items.push_back(it);
        it = '0;
        pending_items.push_back(it);
        it = '1;
        pending_items.push_back(it);
        for (int n = 0; n < N_RANDOM; n++) pending_items.push_back(random_item());
    end

    initial begin
        i_rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        out_ch.ready = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // sender: bursts and gaps, with one drain pause midway
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_ch.valid && in_ch.ready) begin
                void'(pending_items.pop_front());
                n_sent++;
            end
            if (n_sent == 300 && !drain_hold && rotated_expected.size() != 0) begin
                drain_hold <= 1'b1;
            end else if (drain_hold && rotated_expected.size() == 0) begin
                drain_hold <= 1'b0;
                n_sent++;
            end
            if (!(in_ch.valid && !in_ch.ready)) begin
                if (pending_items.size() == 0 || drain_hold
                    || (n_sent == 300 && rotated_expected.size() != 0)) begin
                    in_ch.valid <= 1'b0;
                end else if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    in_ch.valid <= 1'b0;
                end else begin
                    in_ch.valid <= 1'b1;
                    in_ch.data <= pending_items[0];
                    if (burst_left == 0) begin
                        burst_left <= $urandom_range(1, 40);
                        gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end
            end
            if (pending_items.size() == 0 || (pending_items.size() == 1
                && in_ch.valid && in_ch.ready)) begin
                stim_done <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && in_ch.valid && in_ch.ready) begin
            rotated_expected.push_back(rotate_basis(in_ch.data));
        end
    end

    // receiver: stall pattern cycling through free-flowing and choppy phases
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            stall_phase <= stall_phase + 1;
            if (stall_phase[9:8] == 2'd0) out_ch.ready <= 1'b1;
            else if (stall_phase[9:8] == 2'd1) out_ch.ready <= ($urandom_range(0, 3) != 0);
            else if (stall_phase[9:8] == 2'd2) out_ch.ready <= (stall_phase[2:0] != 3'd0);
            else out_ch.ready <= ($urandom_range(0, 1) == 1);
        end
    end

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (rotated_expected.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= 10) $display("unexpected result item %h", out_ch.data);
            end else begin
                want = rotated_expected.pop_front();
                if (want !== out_ch.data) begin
                    n_mismatch++;
                    if (n_mismatch <= 10) begin
                        $display("rotated basis mismatch");
                        $display("  expected %p", want);
                        $display("  actual   %p", out_ch.data);
                    end
                end
            end
        end
    end

    initial begin
        n_mismatch = 0;
        n_sent = 0;
        stim_done = 1'b0;
        drain_hold = 1'b0;
        burst_left = 0;
        gap_left = 0;
        stall_phase = 0;
        wait (stim_done);
        wait (rotated_expected.size() == 0);
        repeat (LATENCY * 4) @(posedge i_clk);
        if (n_mismatch == 0 && rotated_expected.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
